/* rtl/fpa_pkg.sv */
`default_nettype none
package fpa_pkg;
   localparam int FRAC_BITS = 8;
   localparam int WORD_W    = 32;
   localparam int NUM_W     = WORD_W + FRAC_BITS;
   localparam int WIDE_W    = 64;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   typedef enum logic [3:0] {
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_GT, ACT_GE, ACT_LT, ACT_LE,
      ACT_EQ, ACT_NE, ACT_MIN, ACT_MAX, ACT_INC, ACT_DEC, ACT_I2F, ACT_F2I
   } action_type;

   typedef enum logic [1:0] {CLS_SIMPLE, CLS_MUL, CLS_DIV} class_type;

   typedef enum logic [1:0] {ST_OK, ST_SAT, ST_DIV0} status_type;

   typedef struct packed {
      action_type               action;
      class_type                cls;
      logic signed [WORD_W-1:0] a;
      logic signed [WORD_W-1:0] b;
   } item_type;

   typedef struct packed {
      class_type                cls;
      logic                     neg;
      logic signed [WORD_W-1:0] res;
      logic                     cmp;
      status_type               st;
      logic [WIDE_W-1:0]        wide;
      logic [WORD_W-1:0]        rem;
      logic [WORD_W-1:0]        den;
   } stage_type;
endpackage
`default_nettype wire

/* rtl/fpa_front.sv */
`default_nettype none
module fpa_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire logic [3:0]       req_action,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   input  wire logic             q_full,
   output logic                  push,
   output fpa_pkg::item_type     push_item
);
   import fpa_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff, item_in;
   logic     accept;

   assign push      = vld_ff && !q_full;
   assign busy      = vld_ff && q_full;
   assign accept    = start && !busy;
   assign push_item = item_ff;
   assign vld_in    = accept || (vld_ff && !push);

   always_comb begin
      item_in        = item_ff;
      if (accept) begin
         item_in.action = action_type'(req_action);
         item_in.a      = req_operand_a;
         item_in.b      = req_operand_b;
         unique case (action_type'(req_action))
            ACT_MUL: item_in.cls = CLS_MUL;
            ACT_DIV: item_in.cls = CLS_DIV;
            default: item_in.cls = CLS_SIMPLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      item_ff <= item_in;
   end
endmodule
`default_nettype wire

/* rtl/fpa_queue.sv */
`default_nettype none
module fpa_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire fpa_pkg::item_type push_item,
   output logic                   full,
   output logic                   pop,
   output fpa_pkg::item_type      pop_item
);
   import fpa_pkg::*;

   item_type   mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full     = cnt_ff == 2'd2;
   assign pop      = cnt_ff != 2'd0;
   assign pop_item = mem_ff[rd_ff];
   assign wr_in    = push ? !wr_ff : wr_ff;
   assign rd_in    = pop ? !rd_ff : rd_ff;
   assign cnt_in   = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

/* rtl/fpa_back.sv */
`default_nettype none
module fpa_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              pop,
   input  wire fpa_pkg::item_type pop_item,
   output logic                   rsp_valid,
   output logic signed [31:0]     rsp_result_value,
   output logic                   rsp_compare_true,
   output logic [1:0]             rsp_status
);
   import fpa_pkg::*;

   typedef struct packed {
      logic                     sat;
      logic signed [WORD_W-1:0] val;
   } sat_type;

   function automatic sat_type sat33(input logic [WORD_W:0] s);
      sat_type r;
      r.sat = s[WORD_W] != s[WORD_W-1];
      if (r.sat) begin
         r.val = s[WORD_W] ? WORD_MIN : WORD_MAX;
      end else begin
         r.val = s[WORD_W-1:0];
      end
      return r;
   endfunction

   function automatic stage_type div_step(input stage_type s);
      stage_type  o;
      logic [WORD_W:0] sh;
      logic       qb;
      o  = s;
      sh = {s.rem, s.wide[NUM_W-1]};
      qb = sh >= {1'b0, s.den};
      if (qb) begin
         sh = sh - {1'b0, s.den};
      end
      if (s.cls == CLS_DIV) begin
         o.rem              = sh[WORD_W-1:0];
         o.wide[NUM_W-1:0]  = {s.wide[NUM_W-2:0], qb};
      end
      return o;
   endfunction

   stage_type stg_ff [NUM_W+1];
   logic      vld_ff [NUM_W+1];
   stage_type s0_in;
   logic [WORD_W-1:0] ma, mb;
   sat_type   sr;
   logic signed [WORD_W-1:0] hi;

   logic [WIDE_W-1:0] m;
   stage_type         fin;
   logic signed [WORD_W-1:0] res_in;
   status_type        st_in;

   logic              out_vld_ff;
   logic signed [WORD_W-1:0] out_res_ff;
   logic              out_cmp_ff;
   status_type        out_st_ff;

   always_comb begin
      ma     = pop_item.a[WORD_W-1] ? WORD_W'(-pop_item.a) : pop_item.a;
      mb     = pop_item.b[WORD_W-1] ? WORD_W'(-pop_item.b) : pop_item.b;
      hi     = pop_item.a >>> (WORD_W - 1 - FRAC_BITS);
      sr     = sat33({pop_item.a[WORD_W-1], pop_item.a} + {pop_item.b[WORD_W-1], pop_item.b});
      s0_in      = '0;
      s0_in.cls  = CLS_SIMPLE;
      s0_in.neg  = pop_item.a[WORD_W-1] != pop_item.b[WORD_W-1];
      s0_in.st   = ST_OK;
      s0_in.den  = mb;
      unique case (pop_item.action)
         ACT_ADD: begin
            s0_in.res = sr.val;
            s0_in.st  = sr.sat ? ST_SAT : ST_OK;
         end
         ACT_SUB: begin
            sr        = sat33({pop_item.a[WORD_W-1], pop_item.a}
                              - {pop_item.b[WORD_W-1], pop_item.b});
            s0_in.res = sr.val;
            s0_in.st  = sr.sat ? ST_SAT : ST_OK;
         end
         ACT_MUL: begin
            s0_in.cls  = CLS_MUL;
            s0_in.wide = WIDE_W'(ma) * WIDE_W'(mb);
         end
         ACT_DIV: begin
            if (mb == '0) begin
               s0_in.st = ST_DIV0;
               if (pop_item.a[WORD_W-1]) begin
                  s0_in.res = WORD_MIN;
               end else if (pop_item.a != '0) begin
                  s0_in.res = WORD_MAX;
               end
            end else begin
               s0_in.cls  = CLS_DIV;
               s0_in.wide = WIDE_W'(ma) << FRAC_BITS;
            end
         end
         ACT_GT:  s0_in.cmp = pop_item.a >  pop_item.b;
         ACT_GE:  s0_in.cmp = pop_item.a >= pop_item.b;
         ACT_LT:  s0_in.cmp = pop_item.a <  pop_item.b;
         ACT_LE:  s0_in.cmp = pop_item.a <= pop_item.b;
         ACT_EQ:  s0_in.cmp = pop_item.a == pop_item.b;
         ACT_NE:  s0_in.cmp = pop_item.a != pop_item.b;
         ACT_MIN: s0_in.res = (pop_item.b < pop_item.a) ? pop_item.b : pop_item.a;
         ACT_MAX: s0_in.res = (pop_item.b > pop_item.a) ? pop_item.b : pop_item.a;
         ACT_INC: begin
            sr        = sat33({pop_item.a[WORD_W-1], pop_item.a} + 33'd1);
            s0_in.res = sr.val;
            s0_in.st  = sr.sat ? ST_SAT : ST_OK;
         end
         ACT_DEC: begin
            sr        = sat33({pop_item.a[WORD_W-1], pop_item.a} - 33'd1);
            s0_in.res = sr.val;
            s0_in.st  = sr.sat ? ST_SAT : ST_OK;
         end
         ACT_I2F: begin
            if (hi == '0 || hi == '1) begin
               s0_in.res = pop_item.a <<< FRAC_BITS;
            end else begin
               s0_in.res = pop_item.a[WORD_W-1] ? WORD_MIN : WORD_MAX;
               s0_in.st  = ST_SAT;
            end
         end
         ACT_F2I: s0_in.res = pop_item.a >>> FRAC_BITS;
         default: s0_in.res = '0;
      endcase
   end

   always_comb begin
      fin   = stg_ff[NUM_W];
      res_in = fin.res;
      st_in  = fin.st;
      if (fin.cls == CLS_MUL) begin
         m = (fin.wide >> FRAC_BITS) + WIDE_W'(fin.wide[FRAC_BITS-1]);
      end else begin
         m = fin.wide + WIDE_W'({fin.rem, 1'b0} >= {1'b0, fin.den});
      end
      if (fin.cls == CLS_MUL || fin.cls == CLS_DIV) begin
         st_in = ST_OK;
         if (fin.neg) begin
            if (m > 64'h0000_0000_8000_0000) begin
               res_in = WORD_MIN;
               st_in  = ST_SAT;
            end else begin
               res_in = WORD_W'(-m);
            end
         end else begin
            if (m > 64'h0000_0000_7FFF_FFFF) begin
               res_in = WORD_MAX;
               st_in  = ST_SAT;
            end else begin
               res_in = m[WORD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= NUM_W; k++) begin
            vld_ff[k] <= 1'b0;
         end
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff[0] <= pop;
         for (int k = 0; k < NUM_W; k++) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         out_vld_ff <= vld_ff[NUM_W];
      end
      stg_ff[0] <= s0_in;
      for (int k = 0; k < NUM_W; k++) begin
         stg_ff[k+1] <= div_step(stg_ff[k]);
      end
      out_res_ff <= res_in;
      out_cmp_ff <= fin.cmp;
      out_st_ff  <= st_in;
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_result_value = out_res_ff;
   assign rsp_compare_true = out_cmp_ff;
   assign rsp_status       = out_st_ff;
endmodule
`default_nettype wire

/* rtl/fixed_point_alu_q24_8.sv */
// Signed Q24.8 fixed-point ALU.
// Request: drive req_action, req_operand_a and req_operand_b with start; the item
// is taken at a rising edge where start is high and busy is low. Items may be
// issued every cycle; busy rises only if the internal queue fills, which the
// fixed-rate back end prevents in normal use.
// Response: one item per request, in issue order, shown for a single cycle
// with rsp_valid on rsp_result_value, rsp_compare_true and rsp_status.
// The receiver cannot stall; results are dropped if not sampled.
// Every action takes the same route: the front register, the queue entry,
// pipeline stage 0, the divider stages, then the output register. The restoring
// divider makes one quotient bit per pipeline stage over 32 + FRAC_BITS stages.
// Throughput: one item per cycle while busy is low.
// Reset (synchronous, active high) empties the front register, the queue and
// the pipeline; items in flight are lost.
`default_nettype none
module fixed_point_alu_q24_8 (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [3:0]         req_action,
   input  wire logic signed [31:0] req_operand_a,
   input  wire logic signed [31:0] req_operand_b,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_result_value,
   output logic                    rsp_compare_true,
   output logic [1:0]              rsp_status
);
   import fpa_pkg::*;

   localparam int LAT = NUM_W + 4;

   logic     q_full, push, pop;
   item_type push_item, pop_item;

   fpa_front u_front (
      .clock, .reset, .start, .busy, .req_action, .req_operand_a, .req_operand_b,
      .q_full, .push, .push_item
   );

   fpa_queue u_queue (
      .clock, .reset, .push, .push_item, .full(q_full), .pop, .pop_item
   );

   fpa_back u_back (
      .clock, .reset, .pop, .pop_item, .rsp_valid, .rsp_result_value,
      .rsp_compare_true, .rsp_status
   );

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("result missing");

   a_cmp_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_compare_true) |-> (rsp_status == ST_OK && rsp_result_value == '0))
      else $error("comparison result carries data");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != 2'd3))
      else $error("bad status");
endmodule
`default_nettype wire

/* tb/tb_fixed_point_alu_q24_8.sv */
`default_nettype none
module tb_fixed_point_alu_q24_8;
   import fpa_pkg::*;

   localparam int LATENCY = FRAC_BITS + 35;

   typedef struct {
      logic signed [31:0] value;
      logic               cmp;
      status_type         st;
   } alu_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [3:0]         req_action = '0;
   logic signed [31:0] req_operand_a = '0;
   logic signed [31:0] req_operand_b = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic               rsp_compare_true;
   logic [1:0]         rsp_status;

   alu_result_type pending_results[$];
   int             error_count = 0;
   bit             quiet_phase = 1'b0;

   fixed_point_alu_q24_8 dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_operand_a(req_operand_a),
      .req_operand_b(req_operand_b), .rsp_valid(rsp_valid),
      .rsp_result_value(rsp_result_value), .rsp_compare_true(rsp_compare_true),
      .rsp_status(rsp_status)
   );

   always #1 clock = ~clock;

   function automatic alu_result_type saturate(longint v, status_type st);
      alu_result_type r;
      r.cmp = 1'b0;
      r.st = st;
      if (v > longint'(WORD_MAX)) begin
         r.value = WORD_MAX;
         r.st = ST_SAT;
      end else if (v < longint'(WORD_MIN)) begin
         r.value = WORD_MIN;
         r.st = ST_SAT;
      end else begin
         r.value = v[31:0];
      end
      return r;
   endfunction

   function automatic alu_result_type apply_sign(logic [63:0] mag, bit neg);
      longint m;
      if (neg) begin
         if (mag > 64'd2147483648) return saturate(longint'(WORD_MIN) - 1, ST_OK);
         m = mag;
         return saturate(-m, ST_OK);
      end
      if (mag > 64'd2147483647) return saturate(longint'(WORD_MAX) + 1, ST_OK);
      m = mag;
      return saturate(m, ST_OK);
   endfunction

   function automatic alu_result_type compute_alu(action_type act, logic signed [31:0] a,
                                                  logic signed [31:0] b);
      alu_result_type r;
      longint         la, lb;
      logic [63:0]    ma, mb, prod, quo, num, rem;
      la = a;
      lb = b;
      ma = la < 0 ? -la : la;
      mb = lb < 0 ? -lb : lb;
      r = saturate(0, ST_OK);
      case (act)
         ACT_ADD: r = saturate(la + lb, ST_OK);
         ACT_SUB: r = saturate(la - lb, ST_OK);
         ACT_MUL: begin
            prod = ma * mb;
            quo = (prod >> FRAC_BITS) + ((prod >> (FRAC_BITS - 1)) & 64'd1);
            r = apply_sign(quo, (la < 0) != (lb < 0));
         end
         ACT_DIV: begin
            if (lb == 0) begin
               r.st = ST_DIV0;
               r.value = la > 0 ? WORD_MAX : (la < 0 ? WORD_MIN : 32'sd0);
            end else begin
               num = ma << FRAC_BITS;
               quo = num / mb;
               rem = num % mb;
               if (rem >= mb - rem) quo = quo + 1;
               r = apply_sign(quo, (la < 0) != (lb < 0));
            end
         end
         ACT_GT:  r.cmp = a > b;
         ACT_GE:  r.cmp = a >= b;
         ACT_LT:  r.cmp = a < b;
         ACT_LE:  r.cmp = a <= b;
         ACT_EQ:  r.cmp = a == b;
         ACT_NE:  r.cmp = a != b;
         ACT_MIN: r.value = (b < a) ? b : a;
         ACT_MAX: r.value = (b > a) ? b : a;
         ACT_INC: r = saturate(la + 1, ST_OK);
         ACT_DEC: r = saturate(la - 1, ST_OK);
         ACT_I2F: r = saturate(la * (64'sd1 <<< FRAC_BITS), ST_OK);
         default: r.value = a >>> FRAC_BITS;
      endcase
      return r;
   endfunction

   task automatic send_item(action_type act, logic signed [31:0] a, logic signed [31:0] b);
      while (!quiet_phase && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_action <= act;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(compute_alu(act, a, b));
   endtask

   task automatic release_bus();
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      release_bus();
      while (pending_results.size() > 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] edge_operand();
      case ($urandom_range(9))
         0: return WORD_MAX;
         1: return WORD_MIN;
         2: return 32'sd0;
         3: return 32'sd1;
         4: return -32'sd1;
         5: return 32'sd256;
         6: return -32'sd256;
         7: return $signed($urandom_range(65535)) - 32'sd32768;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(ACT_ADD, WORD_MAX, 32'sd1);
      send_item(ACT_SUB, WORD_MIN, 32'sd1);
      send_item(ACT_MUL, WORD_MAX, WORD_MAX);
      send_item(ACT_MUL, WORD_MIN, 32'sd256);
      send_item(ACT_MUL, 32'sd1, 32'sd128);
      send_item(ACT_MUL, -32'sd1, 32'sd128);
      send_item(ACT_DIV, 32'sd256, 32'sd0);
      send_item(ACT_DIV, -32'sd5, 32'sd0);
      send_item(ACT_DIV, 32'sd0, 32'sd0);
      send_item(ACT_DIV, WORD_MIN, -32'sd1);
      send_item(ACT_DIV, 32'sd1, 32'sd512);
      send_item(ACT_GT, WORD_MIN, WORD_MAX);
      send_item(ACT_GE, 32'sd5, 32'sd5);
      send_item(ACT_LT, WORD_MIN, WORD_MAX);
      send_item(ACT_LE, 32'sd5, 32'sd4);
      send_item(ACT_EQ, -32'sd1, -32'sd1);
      send_item(ACT_NE, -32'sd1, -32'sd1);
      send_item(ACT_MIN, 32'sd7, 32'sd7);
      send_item(ACT_MAX, WORD_MIN, WORD_MAX);
      send_item(ACT_INC, WORD_MAX, 32'sd0);
      send_item(ACT_DEC, WORD_MIN, 32'sd0);
      send_item(ACT_I2F, 32'sd8388608, 32'sd0);
      send_item(ACT_I2F, -32'sd8388608, 32'sd0);
      send_item(ACT_F2I, -32'sd1, 32'sd0);
      send_item(ACT_F2I, WORD_MAX, 32'sd0);
   endtask

   task automatic test_random(int count, bit no_gaps);
      quiet_phase = no_gaps;
      for (int i = 0; i < count; i++) begin
         send_item(action_type'($urandom_range(15)),
                   $urandom_range(1) ? edge_operand() : $signed($urandom),
                   $urandom_range(1) ? edge_operand() : $signed($urandom));
      end
      quiet_phase = 1'b0;
   endtask

   always @(posedge clock) begin
      alu_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result %h", rsp_result_value);
            error_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_result_value !== e.value) begin
               $error("result_value: expected %h, got %h", e.value, rsp_result_value);
               error_count++;
            end
            if (rsp_compare_true !== e.cmp) begin
               $error("compare_true: expected %b, got %b", e.cmp, rsp_compare_true);
               error_count++;
            end
            if (rsp_status !== e.st) begin
               $error("status: expected %0d, got %0d", e.st, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      test_random(600, 1'b0);
      drain();
      test_random(500, 1'b1);
      test_random(600, 1'b0);
      drain();
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("fixed_point_alu_q24_8 regression: pass");
      else
         $display("fixed_point_alu_q24_8 regression: fail");
      $finish;
   end

   initial begin
      #200000;
      $display("fixed_point_alu_q24_8 regression: fail");
      $finish;
   end
endmodule
`default_nettype wire
